// File: design/ipv4_header_builder_macros.svh
// Assertion macros for the IPv4 header builder.
// Both macros sample on the rising edge of clock and are disabled in reset.
`ifndef IPV4_HEADER_BUILDER_MACROS_SVH
`define IPV4_HEADER_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define IPV4HB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IPV4HB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IPV4HB_ASSERT_SAME(label, ante, cons, msg)
`define IPV4HB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/ipv4hb_pkg.sv
package ipv4hb_pkg;

   // Fixed header contents
   localparam logic [15:0] VERSION_IHL_TOS = 16'h4500;
   localparam logic [7:0]  TTL_VALUE       = 8'h40;
   localparam logic [15:0] HEADER_BYTES    = 16'd20;

   // Word positions within the ten-word header
   localparam logic [3:0] WORD_VER_TOS   = 4'd0;
   localparam logic [3:0] WORD_TOTAL_LEN = 4'd1;
   localparam logic [3:0] WORD_IDENT     = 4'd2;
   localparam logic [3:0] WORD_FLAGS     = 4'd3;
   localparam logic [3:0] WORD_TTL_PROTO = 4'd4;
   localparam logic [3:0] WORD_CHECKSUM  = 4'd5;
   localparam logic [3:0] WORD_SRC_HI    = 4'd6;
   localparam logic [3:0] WORD_SRC_LO    = 4'd7;
   localparam logic [3:0] WORD_DST_HI    = 4'd8;
   localparam logic [3:0] WORD_DST_LO    = 4'd9;
   localparam logic [3:0] WORD_LAST      = WORD_DST_LO;

   // Finished header handed from the checksum pipeline to the serialiser
   typedef struct packed {
      logic [31:0] dst;
      logic [31:0] src;
      logic [7:0]  proto;
      logic [15:0] total;
      logic [15:0] checksum;
   } hdr_type;

endpackage

// File: design/ipv4hb_csum_pipe.sv
module ipv4hb_csum_pipe import ipv4hb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] in_dst,
   input  logic [7:0]  in_proto,
   input  logic [15:0] in_plen,
   input  logic [31:0] src_addr,
   output logic        out_valid,
   input  logic        out_ready,
   output hdr_type     out_hdr
);

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic        s1_ready, s2_ready, s3_ready, s4_ready;

   logic [31:0] s1_dst_ff, s2_dst_ff, s3_dst_ff;
   logic [31:0] s1_src_ff, s2_src_ff, s3_src_ff;
   logic [7:0]  s1_proto_ff, s2_proto_ff, s3_proto_ff;
   logic [15:0] s1_total_ff, s2_total_ff, s3_total_ff;
   logic [15:0] s1_total_in;

   logic [17:0] s2_sum_a_ff, s2_sum_b_ff;
   logic [17:0] s2_sum_a_in, s2_sum_b_in;
   logic [18:0] s3_full;
   logic [16:0] s3_fold_ff, s3_fold_in;
   logic [15:0] s4_csum_in;
   hdr_type     s4_hdr_ff;

   // Each stage moves when it is empty or the next one takes its word
   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: total length, wraps modulo 2^16
   assign s1_total_in = 16'(in_plen + HEADER_BYTES);

   // Stage 2: two partial sums of the header words (checksum word at zero)
   assign s2_sum_a_in = 18'(VERSION_IHL_TOS) + 18'(s1_total_ff) + 18'({TTL_VALUE, s1_proto_ff});
   assign s2_sum_b_in = 18'(s1_src_ff[31:16]) + 18'(s1_src_ff[15:0])
                      + 18'(s1_dst_ff[31:16]) + 18'(s1_dst_ff[15:0]);

   // Stage 3: full sum and first fold
   assign s3_full    = 19'(s2_sum_a_ff) + 19'(s2_sum_b_ff);
   assign s3_fold_in = 17'(s3_full[15:0]) + 17'(s3_full[18:16]);

   // Stage 4: last end-around carry, then invert
   assign s4_csum_in = ~(s3_fold_ff[15:0] + 16'(s3_fold_ff[16]));

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_dst_ff   <= in_dst;
         s1_src_ff   <= src_addr;
         s1_proto_ff <= in_proto;
         s1_total_ff <= s1_total_in;
      end
      if (s2_ready) begin
         s2_dst_ff   <= s1_dst_ff;
         s2_src_ff   <= s1_src_ff;
         s2_proto_ff <= s1_proto_ff;
         s2_total_ff <= s1_total_ff;
         s2_sum_a_ff <= s2_sum_a_in;
         s2_sum_b_ff <= s2_sum_b_in;
      end
      if (s3_ready) begin
         s3_dst_ff   <= s2_dst_ff;
         s3_src_ff   <= s2_src_ff;
         s3_proto_ff <= s2_proto_ff;
         s3_total_ff <= s2_total_ff;
         s3_fold_ff  <= s3_fold_in;
      end
      if (s4_ready) begin
         s4_hdr_ff.dst      <= s3_dst_ff;
         s4_hdr_ff.src      <= s3_src_ff;
         s4_hdr_ff.proto    <= s3_proto_ff;
         s4_hdr_ff.total    <= s3_total_ff;
         s4_hdr_ff.checksum <= s4_csum_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_hdr   = s4_hdr_ff;

endmodule

// File: design/ipv4hb_serializer.sv
module ipv4hb_serializer import ipv4hb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  hdr_type     in_hdr,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [15:0] out_word,
   output logic [3:0]  out_index,
   output logic        out_last
);

   logic        busy_ff, busy_in;
   logic [3:0]  pos_ff, pos_in;
   hdr_type     hdr_ff;
   logic        at_last;
   logic        word_taken;
   logic        load;

   assign at_last    = (pos_ff == WORD_LAST);
   assign word_taken = busy_ff && out_ready;
   // A new header loads when idle or as the final word leaves
   assign in_ready   = !busy_ff || (out_ready && at_last);
   assign load       = in_valid && in_ready;

   // Position and occupancy
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (word_taken) begin
         if (at_last) begin
            pos_in  = WORD_VER_TOS;
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 4'd1;
         end
      end
      if (load) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= WORD_VER_TOS;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) hdr_ff <= in_hdr;
   end

   // Word select
   always_comb begin
      case (pos_ff)
         WORD_VER_TOS:   out_word = VERSION_IHL_TOS;
         WORD_TOTAL_LEN: out_word = hdr_ff.total;
         WORD_IDENT:     out_word = 16'h0000;
         WORD_FLAGS:     out_word = 16'h0000;
         WORD_TTL_PROTO: out_word = {TTL_VALUE, hdr_ff.proto};
         WORD_CHECKSUM:  out_word = hdr_ff.checksum;
         WORD_SRC_HI:    out_word = hdr_ff.src[31:16];
         WORD_SRC_LO:    out_word = hdr_ff.src[15:0];
         WORD_DST_HI:    out_word = hdr_ff.dst[31:16];
         WORD_DST_LO:    out_word = hdr_ff.dst[15:0];
         default:        out_word = 16'h0000;
      endcase
   end

   assign out_valid = busy_ff;
   assign out_index = pos_ff;
   assign out_last  = at_last;

endmodule

// File: design/ipv4_header_builder.sv
// Channel  | Direction | Handshake              | Contents
// req      | in        | req_tvalid/req_tready  | one packet request
// rsp      | out       | rsp_tvalid/rsp_tready  | ten header words per request
// csr      | in        | csr_wr_en              | source address register
//
// A request passes a four-stage checksum pipeline (latch and total length,
// partial sums, full sum and fold, final fold and invert) and then reaches
// the serialiser, which sends ten words over the single 16-bit result port
// at one per cycle while rsp_tready is high, and loads the next header as
// the final word leaves. Up to five requests may be in flight. Reset clears
// all valid bits and the source address. A stall on rsp backs up through
// the stages without dropping a word.
`include "ipv4_header_builder_macros.svh"

module ipv4_header_builder import ipv4hb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] dst_addr, [39:32] protocol_number, [55:40] payload_length
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] header_word, [19:16] word_index, [23:20] zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0] source_address_ff;
   logic        hdr_valid;
   logic        hdr_ready;
   hdr_type     hdr;
   logic [15:0] word;
   logic [3:0]  index;
   logic        mid_taken;
   logic        last_taken;
   logic        at_first;
   logic [3:0]  next_index;

   // Source address register
   always_ff @(posedge clock) begin
      if (reset) begin
         source_address_ff <= 32'h0;
      end else if (csr_wr_en) begin
         source_address_ff <= csr_wr_data;
      end
   end

   ipv4hb_csum_pipe u_csum_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_dst    (req_tdata[31:0]),
      .in_proto  (req_tdata[39:32]),
      .in_plen   (req_tdata[55:40]),
      .src_addr  (source_address_ff),
      .out_valid (hdr_valid),
      .out_ready (hdr_ready),
      .out_hdr   (hdr)
   );

   ipv4hb_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hdr_valid),
      .in_ready  (hdr_ready),
      .in_hdr    (hdr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word),
      .out_index (index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, index, word};

   // Handshake terms for the checks
   assign mid_taken  = rsp_tvalid && rsp_tready && !rsp_tlast;
   assign last_taken = rsp_tvalid && rsp_tready && rsp_tlast;
   assign at_first   = rsp_tvalid && (index == WORD_VER_TOS);
   assign next_index = index + 4'd1;

   // Checks
   `IPV4HB_ASSERT_SAME(a_last_flag, rsp_tvalid, rsp_tlast == (index == WORD_LAST), "last flag")
   `IPV4HB_ASSERT_NEXT(a_order, mid_taken, rsp_tvalid && index == $past(next_index), "word order")
   `IPV4HB_ASSERT_SAME(a_first_word, at_first, word == VERSION_IHL_TOS, "first word")
   `IPV4HB_ASSERT_NEXT(a_restart, last_taken, !rsp_tvalid || index == WORD_VER_TOS, "restart")

endmodule
